[sv/gaussian_blur_5x5_top_macros.svh]
// Assertion macros shared by the blur block; clk and rst are taken from the asserting module.
`ifndef GAUSSIAN_BLUR_5X5_TOP_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GB5_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GB5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/gb5_pkg.sv]
// Shared types, constants and the binomial tap sum for the 5x5 blur.
`timescale 1ns / 1ps

package gb5_pkg;

  localparam int PIX_W         = 8;
  localparam int WIN           = 5;
  localparam int ROWS_HELD     = WIN - 1;
  localparam int LINE_W        = ROWS_HELD * PIX_W;
  localparam int BORDER        = WIN / 2;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_ROWS      = 4096;
  localparam int VSUM_W        = 12;
  localparam int SUM_W         = 16;
  localparam int COL_W         = 10;
  localparam int ROW_W         = 12;
  localparam int WIDTH_REG_W   = 11;
  localparam int HEIGHT_REG_W  = 13;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int OUT_DATA_W    = 32;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // One window column, byte 0 is the oldest row.
  typedef logic [WIN-1:0][PIX_W-1:0] gb5_col_t;

  typedef struct packed {
    logic shift;  // take the neighbor's column
    logic load;   // capture the weighted column sum
  } gb5_cell_ctl_t;

  typedef struct packed {
    logic             emit;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } gb5_meta_t;

  // a + 4b + 6c + 4d + e
  function automatic logic [SUM_W-1:0] tap_sum(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b,
                                                input logic [SUM_W-1:0] c,
                                                input logic [SUM_W-1:0] d,
                                                input logic [SUM_W-1:0] e);
    logic [SUM_W-1:0] bd;
    bd = b + d;
    return a + e + (bd << 2) + (c << 2) + (c << 1);
  endfunction

endpackage

[sv/gb5_line_mem.sv]
// Line store memory: four previous rows packed per column, with write-to-read forwarding.
`timescale 1ns / 1ps

module gb5_line_mem #(
  parameter int unsigned DEPTH = gb5_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [gb5_pkg::LINE_W-1:0]  wr_data,
  output logic [gb5_pkg::LINE_W-1:0]  rd_data
);
  import gb5_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] rd_q;
  logic [LINE_W-1:0] fwd_q;
  logic              fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A write landing on the same column in the same cycle wins over the array.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      fwd   <= wr_en && (wr_addr == rd_addr);
      fwd_q <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_q : rd_q;

endmodule

[sv/gb5_cell.sv]
// One window column cell: holds five pixels and their vertical binomial sum.
`timescale 1ns / 1ps

module gb5_cell (
  input  logic                            clk,
  input  gb5_pkg::gb5_cell_ctl_t          ctl,
  input  gb5_pkg::gb5_col_t               col_in,
  output gb5_pkg::gb5_col_t               col_out,
  output logic [gb5_pkg::VSUM_W-1:0]      vsum
);
  import gb5_pkg::*;

  gb5_col_t         col;
  logic [SUM_W-1:0] vsum_next;

  assign vsum_next = tap_sum(SUM_W'(col[0]), SUM_W'(col[1]), SUM_W'(col[2]),
                             SUM_W'(col[3]), SUM_W'(col[4]));

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col <= col_in;
    end
    if (ctl.load) begin
      vsum <= vsum_next[VSUM_W-1:0];
    end
  end

  assign col_out = col;

endmodule

[sv/gaussian_blur_5x5_top.sv]
// Top level of the streaming 5x5 binomial blur.
//
// Pixels enter on s_axis in raster order, one word per pixel. Each interior
// pixel (two or more from every edge) leaves on m_axis with its column, row
// and tlast on the last interior pixel of the frame; border pixels give no word.
// Frame size comes from cfg: index 0 image_width, index 1 image_height, to be
// written by the user while no pixel is in flight (the block does not check).
// Throughput is one pixel per clock while m_axis does not stall: the line
// store does one read and one write per cycle and the window is a chain of
// five column cells. The pixel completing a window passes the line read,
// the window shift, the column sums and the weighted total into the output
// register; the line read happens on the accepting edge itself.
// A stalled m_axis holds its word; up to three more pixels are taken into
// the pipeline before s_axis_tready drops.
// Reset (rst, synchronous) empties the pipeline, zeroes the position
// counters and sets the frame to 640 x 480; the line store keeps its contents
// and needs no clearing pass.
`timescale 1ns / 1ps

`include "gaussian_blur_5x5_top_macros.svh"

module gaussian_blur_5x5_top #(
  parameter int unsigned MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gb5_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gb5_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [gb5_pkg::PIX_W-1:0]          s_axis_tdata,  // [7:0] pixel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] blurred, [17:8] out_col, [29:18] out_row, [31:30] zero
  output logic [gb5_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast   // frame_last
);
  import gb5_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
                          $clog2(MAX_WIDTH + 1) : WIDTH_REG_W;
  localparam int XW     = (CW > COL_W) ? CW : COL_W;
  localparam int PAD_W  = OUT_DATA_W - (PIX_W + COL_W + ROW_W);

  // configuration
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;

  // position of the next pixel
  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;

  logic [WCMP_W-1:0]       w_use;
  logic [HEIGHT_REG_W-1:0] h_use;
  logic                    row_end;
  logic                    frame_end;
  logic                    emit;
  logic [XW-1:0]           col_m2;
  logic                    accept;

  // pipeline stages
  logic             v1, v2, v3;
  logic             en1, en2, en3;
  logic             rdy_out;
  logic [PIX_W-1:0] px1;
  logic [CW-1:0]    addr1;
  gb5_meta_t        meta1, meta2, meta3;

  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;
  gb5_col_t          new_col;
  gb5_cell_ctl_t     cell_ctl;
  gb5_col_t          cell_in  [WIN];
  gb5_col_t          cell_col [WIN];
  logic [VSUM_W-1:0] vsum     [WIN];
  logic [SUM_W-1:0]  hsum;

  // output register
  logic             out_valid;
  logic [PIX_W-1:0] blurred_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic             last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    w_use = WCMP_W'(image_width);
    if (image_width == '0) begin
      w_use = WCMP_W'(1);
    end else if (WCMP_W'(image_width) > WCMP_W'(MAX_WIDTH)) begin
      w_use = WCMP_W'(MAX_WIDTH);
    end
    h_use = image_height;
    if (image_height == '0) begin
      h_use = HEIGHT_REG_W'(1);
    end else if (image_height > HEIGHT_REG_W'(MAX_ROWS)) begin
      h_use = HEIGHT_REG_W'(MAX_ROWS);
    end
  end

  assign row_end   = (WCMP_W'(col_count) + WCMP_W'(1)) >= w_use;
  assign frame_end = row_end &&
                     ((HEIGHT_REG_W'(row_count) + HEIGHT_REG_W'(1)) >= h_use);
  assign emit      = (WCMP_W'(col_count) >= WCMP_W'(WIN - 1)) &&
                     (row_count >= ROW_W'(WIN - 1));
  assign col_m2    = XW'(col_count) - XW'(BORDER);

  // handshake chain, back to front
  assign rdy_out       = !out_valid || m_axis_tready;
  assign en3           = v3 && rdy_out;
  assign en2           = v2 && (!v3 || en3);
  assign en1           = v1 && (!v2 || en2);
  assign s_axis_tready = !v1 || en1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= frame_end ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (en1) begin
        v1 <= 1'b0;
      end
      if (en1) begin
        v2 <= 1'b1;
      end else if (en2) begin
        v2 <= 1'b0;
      end
      if (en2) begin
        v3 <= 1'b1;
      end else if (en3) begin
        v3 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px1        <= s_axis_tdata;
      addr1      <= col_count;
      meta1.emit <= emit;
      meta1.col  <= col_m2[COL_W-1:0];
      meta1.row  <= row_count - ROW_W'(BORDER);
      meta1.last <= frame_end;
    end
    if (en1) begin
      meta2 <= meta1;
    end
    if (en2) begin
      meta3 <= meta2;
    end
  end

  gb5_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .wr_en   (en1),
    .wr_addr (addr1),
    .wr_data (line_wr),
    .rd_data (line_rd)
  );

  // new column: four stored rows plus the incoming pixel; store it back moved up one row
  assign new_col = {px1, line_rd};
  assign line_wr = {px1, line_rd[LINE_W-1:PIX_W]};

  assign cell_ctl.shift = en1;
  assign cell_ctl.load  = en2;

  for (genvar j = 0; j < WIN; j++) begin : g_cell
    if (j == WIN - 1) begin : g_entry
      assign cell_in[j] = new_col;
    end else begin : g_link
      assign cell_in[j] = cell_col[j + 1];
    end
    gb5_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .col_in  (cell_in[j]),
      .col_out (cell_col[j]),
      .vsum    (vsum[j])
    );
  end

  // The total never exceeds 65280, so dropping the low byte needs no clamp.
  assign hsum = tap_sum(SUM_W'(vsum[0]), SUM_W'(vsum[1]), SUM_W'(vsum[2]),
                        SUM_W'(vsum[3]), SUM_W'(vsum[4]));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (en3 && meta3.emit) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && meta3.emit) begin
      blurred_q <= hsum[SUM_W-1:SUM_W-PIX_W];
      out_col_q <= meta3.col;
      out_row_q <= meta3.row;
      last_q    <= meta3.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {PAD_W'(0), out_row_q, out_col_q, blurred_q};
  assign m_axis_tlast  = last_q;

  `GB5_ASSERT_NEXT(a_frame_wrap, accept && frame_end, (col_count == '0) && (row_count == '0), "position counters did not wrap at frame end")
  `GB5_ASSERT_NEXT(a_s3_hold, v3 && !en3, v3 && $stable(meta3), "last stage lost or changed a word while blocked")
  `GB5_ASSERT_NOW(a_out_row_range, m_axis_tvalid, (out_row_q >= ROW_W'(BORDER)) && (out_row_q <= ROW_W'(MAX_ROWS - 1 - BORDER)), "result row outside the interior")
  `GB5_ASSERT_NOW(a_col_bound, 1'b1, WCMP_W'(col_count) < WCMP_W'(MAX_WIDTH), "column counter beyond line store depth")

endmodule

[sim/blur_predict_check.sv]
// Predictor and checker for the 5x5 blur: watches the register, pixel and result ports.
`timescale 1ns / 1ps

module blur_predict_check #(
  parameter int unsigned MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gb5_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gb5_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [gb5_pkg::PIX_W-1:0]         s_axis_tdata,   // [7:0] pixel
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] blurred, [17:8] out_col, [29:18] out_row, [31:30] zero
  input  logic [gb5_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              m_axis_tlast,   // frame_last
  output int                                fail_count,
  output int                                words_waiting,
  output int                                words_checked,
  output int                                frames_closed
);
  import gb5_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } blur_word_t;

  localparam logic [4:0][3:0] BINOMIAL = {4'd1, 4'd4, 4'd6, 4'd4, 4'd1};

  logic [PIX_W-1:0]        held_rows [ROWS_HELD][MAX_WIDTH];
  logic [PIX_W-1:0]        win [WIN][WIN];
  int unsigned             col_pos = 0;
  int unsigned             row_pos = 0;
  logic [WIDTH_REG_W-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
  blur_word_t              blur_q [$];
  int                      errs = 0;
  int                      checked = 0;
  int                      frames = 0;

  assign fail_count    = errs;
  assign words_checked = checked;
  assign frames_closed = frames;

  function automatic int unsigned size_in_use(input int unsigned v, input int unsigned cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  function automatic void take_pixel(input logic [PIX_W-1:0] px);
    int unsigned w, h, ci, sum, v;
    int i, j;
    logic [PIX_W-1:0] fresh [WIN];
    logic row_end, frame_end;
    blur_word_t word;
    w = size_in_use(width_reg, MAX_WIDTH);
    h = size_in_use(height_reg, MAX_ROWS);
    ci = col_pos % MAX_WIDTH;
    row_end = (col_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    for (i = 0; i < ROWS_HELD; i++) fresh[i] = held_rows[i][ci];
    fresh[WIN-1] = px;
    // shift the window left, the new column enters on the right
    for (i = 0; i < WIN; i++) begin
      for (j = 0; j < WIN - 1; j++) win[i][j] = win[i][j+1];
      win[i][WIN-1] = fresh[i];
    end
    // age each held row by one, the new pixel becomes the newest row
    for (i = 0; i < ROWS_HELD; i++) held_rows[i][ci] = fresh[i+1];
    if (row_pos >= 4 && col_pos >= 4) begin
      sum = 0;
      for (i = 0; i < WIN; i++)
        for (j = 0; j < WIN; j++)
          sum += int'(BINOMIAL[i]) * int'(BINOMIAL[j]) * int'(win[i][j]);
      v = sum >> 8;
      if (v > 255) v = 255;
      word.blurred = PIX_W'(v);
      word.col     = COL_W'(col_pos - 2);
      word.row     = ROW_W'(row_pos - 2);
      word.last    = frame_end;
      blur_q.push_back(word);
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic void flag(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    errs++;
    $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
  endfunction

  function automatic void check_word();
    blur_word_t seen, want;
    string at;
    seen.blurred = m_axis_tdata[7:0];
    seen.col     = m_axis_tdata[17:8];
    seen.row     = m_axis_tdata[29:18];
    seen.last    = m_axis_tlast;
    if (seen.last === 1'b1) frames++;
    if (blur_q.size() == 0) begin
      errs++;
      $display("%0t ns: word with none expected: blurred %0d col %0d row %0d last %0d",
               $time, seen.blurred, seen.col, seen.row, seen.last);
      return;
    end
    want = blur_q.pop_front();
    checked++;
    at = $sformatf("at row %0d col %0d:", want.row, want.col);
    if (seen.blurred !== want.blurred) flag({at, " blurred"}, want.blurred, seen.blurred);
    if (seen.col !== want.col) flag({at, " out_col"}, want.col, seen.col);
    if (seen.row !== want.row) flag({at, " out_row"}, want.row, seen.row);
    if (seen.last !== want.last) flag({at, " frame_last"}, want.last, seen.last);
  endfunction

  always @(posedge clk) begin : track
    int i, j;
    if (rst) begin
      for (i = 0; i < ROWS_HELD; i++)
        for (j = 0; j < MAX_WIDTH; j++)
          held_rows[i][j] = '0;
      for (i = 0; i < WIN; i++)
        for (j = 0; j < WIN; j++)
          win[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data[WIDTH_REG_W-1:0];
        else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_data[HEIGHT_REG_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_word();
    end
    words_waiting <= blur_q.size();
  end

endmodule

[sim/tb.sv]
// Testbench top for the 5x5 blur: pixel frames, register writes, flow control and verdict.
`timescale 1ns / 1ps

module tb;
  import gb5_pkg::*;

  typedef enum int {PIX_RANDOM, PIX_BLACK, PIX_WHITE, PIX_SPECKLE, PIX_RAMP} pixel_mix_t;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_PIXELS = 460;
  localparam int unsigned CALM_FROM     = 350;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata;   // [7:0] pixel
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [7:0] blurred, [17:8] out_col, [29:18] out_row, [31:30] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;   // frame_last

  int          fail_count, words_waiting, words_checked, frames_closed;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned pixels_sent = 0;

  gaussian_blur_5x5_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  blur_predict_check blur_watch (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .words_waiting (words_waiting),
    .words_checked (words_checked),
    .frames_closed (frames_closed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // output side: ready most of the time, stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, words_waiting);
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input pixel_mix_t mix);
    case (mix)
      PIX_BLACK:   return '0;
      PIX_WHITE:   return '1;
      PIX_SPECKLE: return $urandom_range(0, 1) ? '1 : '0;
      PIX_RAMP:    return PIX_W'(pixels_sent * 3);
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixels(input int unsigned count, input pixel_mix_t mix);
    repeat (count) begin
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pick_pixel(mix);
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      pixels_sent++;
    end
  endtask

  // hold the input until every expected word is out, then let the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_frame(input logic [CFG_DATA_W-1:0] width_val,
                           input logic [CFG_DATA_W-1:0] height_val, input pixel_mix_t mix);
    settle();
    write_reg(REG_IMAGE_WIDTH, width_val);
    write_reg(REG_IMAGE_HEIGHT, height_val);
    send_pixels(clamp_size(width_val[WIDTH_REG_W-1:0], MAX_WIDTH_DEF) *
                clamp_size(height_val, MAX_ROWS), mix);
  endtask

  initial begin : stimulus
    int unsigned w, h, start, random_pixels;
    pixel_mix_t mix;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_IMAGE_WIDTH;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset size is 640 x 480; narrow to 5 x 5 partway through the first row
    send_pixels(12, PIX_RANDOM);
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(5));
    send_pixels(21, PIX_RAMP);

    run_frame(5, 5, PIX_WHITE);
    run_frame(5, 5, PIX_BLACK);
    run_frame(6, 7, PIX_SPECKLE);
    run_frame(0, 5, PIX_RANDOM);
    run_frame(4, 9, PIX_RANDOM);
    run_frame(9, 4, PIX_RANDOM);
    run_frame(7, 0, PIX_RANDOM);

    // all ones into the width register: 2047 kept, capped to the line length;
    // then narrow mid-row to close the single-row frame
    settle();
    write_reg(REG_IMAGE_WIDTH, '1);
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
    send_pixels(20, PIX_RAMP);
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
    send_pixels(1, PIX_RAMP);

    // tallest height capped to 4096, then lowered mid-frame to end at row seven
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
    write_reg(REG_IMAGE_HEIGHT, '1);
    send_pixels(30, PIX_RANDOM);
    settle();
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(8));
    send_pixels(10, PIX_RANDOM);

    // narrow mid-row: the column already past the new width closes the row
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(12));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(9));
    send_pixels(71, PIX_RANDOM);
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(6));
    send_pixels(19, PIX_RANDOM);

    // widen mid-frame after five rows; columns 10 and 11 hold full rows from above
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(10));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(8));
    send_pixels(50, PIX_RANDOM);
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(12));
    send_pixels(36, PIX_SPECKLE);

    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      if (random_pixels >= CALM_FROM) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 20);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
      mix = ($urandom_range(0, 3) != 0) ? PIX_RANDOM :
            pixel_mix_t'($urandom_range(PIX_BLACK, PIX_RAMP));
      start = pixels_sent;
      run_frame(CFG_DATA_W'(w), CFG_DATA_W'(h), mix);
      random_pixels += pixels_sent - start;
    end

    settle();
    $display("%0d pixels sent, %0d blurred words checked, %0d frame ends seen",
             pixels_sent, words_checked, frames_closed);
    $display("widths 0 to 2047 and heights 0 to 8191 written, some of them mid-frame");
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

[gaussian_blur_5x5_top.f]
+incdir+sv
sv/gb5_pkg.sv
sv/gb5_line_mem.sv
sv/gb5_cell.sv
sv/gaussian_blur_5x5_top.sv
sim/blur_predict_check.sv
sim/tb.sv
